>>> hdl/knn_pkg.sv
package knn_pkg;

   localparam int COORD_W = 10;
   localparam int DIST_W  = 11;
   localparam int INDEX_W = 8;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } point_type;

   // control broadcast to every cell of the rank chain
   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } cell_ctrl_type;

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic [COORD_W-1:0] r;
      r = (a > b) ? (a - b) : (b - a);
      return r;
   endfunction

endpackage

>>> hdl/knn_cell.sv
module knn_cell #(
   parameter int IndexWidth = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  knn_pkg::cell_ctrl_type       ctrl,
   input  logic [knn_pkg::DIST_W-1:0]   cand_dist,
   input  logic [IndexWidth-1:0]        cand_idx,
   input  knn_pkg::point_type           cand_point,
   input  logic                         prev_hit,
   input  logic                         left_valid,
   input  logic [knn_pkg::DIST_W-1:0]   left_dist,
   input  logic [IndexWidth-1:0]        left_idx,
   input  knn_pkg::point_type           left_point,
   input  logic                         right_valid,
   input  logic [knn_pkg::DIST_W-1:0]   right_dist,
   input  logic [IndexWidth-1:0]        right_idx,
   input  knn_pkg::point_type           right_point,
   output logic                         hit,
   output logic                         valid,
   output logic [knn_pkg::DIST_W-1:0]   slot_dist,
   output logic [IndexWidth-1:0]        idx,
   output knn_pkg::point_type           point
);
   import knn_pkg::*;

   logic                  valid_ff, valid_in;
   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic [IndexWidth-1:0] idx_ff, idx_in;
   point_type             point_ff, point_in;

   // candidate belongs here or earlier: empty slot or strictly closer
   assign hit = !valid_ff || (cand_dist < dist_ff);

   always_comb begin
      valid_in = valid_ff;
      dist_in  = dist_ff;
      idx_in   = idx_ff;
      point_in = point_ff;
      priority if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.insert) begin
         if (prev_hit) begin
            // candidate lands above, move down by one rank
            valid_in = left_valid;
            dist_in  = left_dist;
            idx_in   = left_idx;
            point_in = left_point;
         end else if (hit) begin
            valid_in = 1'b1;
            dist_in  = cand_dist;
            idx_in   = cand_idx;
            point_in = cand_point;
         end
      end else if (ctrl.shift) begin
         valid_in = right_valid;
         dist_in  = right_dist;
         idx_in   = right_idx;
         point_in = right_point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      dist_ff  <= dist_in;
      idx_ff   <= idx_in;
      point_ff <= point_in;
   end

   assign valid     = valid_ff;
   assign slot_dist = dist_ff;
   assign idx       = idx_ff;
   assign point     = point_ff;

endmodule

>>> hdl/k_nearest_manhattan_points.sv
// sequence: clear and append finish on acceptance; a query in range passes through the center,
// scan and drain states to its first result, an out-of-range one goes straight to emitting, then
// NEIGHBOUR_COUNT results, one per accepted beat
// throughput: one request at a time, as requests are taken only in the idle state
// (one stored point read per cycle during the scan)
// reset: synchronous, active high; empties the table and the rank chain, returns to idle
module k_nearest_manhattan_points #(
   parameter int NEIGHBOUR_COUNT = 5,
   parameter int TABLE_DEPTH     = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // point_x[9:0], point_y[19:10], query_index[27:20], zero
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // neighbour_x[9:0], neighbour_y[19:10],
                                    // neighbour_index[27:20], neighbour_distance[38:28], zero
   output logic [0:0]  rsp_tuser,   // slot_valid[0]
   output logic        rsp_tlast    // last_result
);
   import knn_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);        // table address
   localparam int CW = $clog2(TABLE_DEPTH + 1);    // count, holds the depth itself
   localparam int QW = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int KW = $clog2(NEIGHBOUR_COUNT + 1);

   // request fields
   logic [COORD_W-1:0] req_x, req_y;
   logic [INDEX_W-1:0] req_qi;
   logic               req_fire, rsp_fire;
   logic               query_in_range;

   assign req_x  = req_tdata[9:0];
   assign req_y  = req_tdata[19:10];
   assign req_qi = req_tdata[27:20];

   // control state
   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [KW-1:0]      emit_ff, emit_in;
   point_type          center_ff, center_in;

   // point table, one write and one registered read port
   point_type          table_mem [TABLE_DEPTH];
   point_type          rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[count_ff[AW-1:0]] <= '{row: req_x, col: req_y};
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // scan pipeline: s1 = table read in flight, s2 = distance computed
   logic               s1_valid_ff, s1_valid_in;
   logic [AW-1:0]      s1_idx_ff, s1_idx_in;
   logic               s2_valid_ff;
   logic [DIST_W-1:0]  s2_dist_ff;
   logic [AW-1:0]      s2_idx_ff;
   point_type          s2_point_ff;

   cell_ctrl_type      ctrl;

   assign req_fire       = req_tvalid && req_tready;
   assign rsp_fire       = rsp_tvalid && rsp_tready;
   assign query_in_range = QW'(req_qi) < QW'(count_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      emit_in     = emit_ff;
      center_in   = center_ff;
      s1_valid_in = 1'b0;
      s1_idx_in   = s1_idx_ff;
      rd_addr     = ptr_ff[AW-1:0];
      wr_en       = 1'b0;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      ctrl        = '{clear: 1'b0, insert: s2_valid_ff, shift: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            rd_addr    = AW'(req_qi);
            if (req_fire) begin
               unique case (req_tuser)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     // full table drops the point
                     if (count_ff < CW'(TABLE_DEPTH)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     ctrl.clear = 1'b1;
                     emit_in    = '0;
                     ptr_in     = '0;
                     // out of range query emits only empty slots
                     state_in   = query_in_range ? ST_CENTER : ST_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CENTER: begin
            // read data now holds the queried point, start scan at entry zero
            center_in   = rd_data_ff;
            rd_addr     = '0;
            s1_valid_in = 1'b1;
            s1_idx_in   = '0;
            ptr_in      = CW'(1);
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (ptr_ff < count_ff) begin
               s1_valid_in = 1'b1;
               s1_idx_in   = ptr_ff[AW-1:0];
               ptr_in      = ptr_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_fire) begin
               ctrl.shift = 1'b1;
               emit_in    = emit_ff + 1'b1;
               if (emit_ff == KW'(NEIGHBOUR_COUNT - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
      ptr_ff      <= ptr_in;
      emit_ff     <= emit_in;
      center_ff   <= center_in;
      s1_idx_ff   <= s1_idx_in;
      // manhattan distance of the entry just read
      s2_dist_ff  <= {1'b0, abs_diff(rd_data_ff.row, center_ff.row)}
                   + {1'b0, abs_diff(rd_data_ff.col, center_ff.col)};
      s2_idx_ff   <= s1_idx_ff;
      s2_point_ff <= rd_data_ff;
   end

   // rank chain, nearest in cell zero; inserts push entries down, results shift up
   logic              cell_hit   [NEIGHBOUR_COUNT];
   logic              cell_valid [NEIGHBOUR_COUNT];
   logic [DIST_W-1:0] cell_dist  [NEIGHBOUR_COUNT];
   logic [AW-1:0]     cell_idx   [NEIGHBOUR_COUNT];
   point_type         cell_point [NEIGHBOUR_COUNT];

   for (genvar i = 0; i < NEIGHBOUR_COUNT; i++) begin : g_cell
      logic              prev_hit;
      logic              left_valid,  right_valid;
      logic [DIST_W-1:0] left_dist,   right_dist;
      logic [AW-1:0]     left_idx,    right_idx;
      point_type         left_point,  right_point;

      if (i == 0) begin : g_head
         assign prev_hit   = 1'b0;
         assign left_valid = 1'b0;
         assign left_dist  = '0;
         assign left_idx   = '0;
         assign left_point = '0;
      end else begin : g_body
         assign prev_hit   = cell_hit[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_dist  = cell_dist[i-1];
         assign left_idx   = cell_idx[i-1];
         assign left_point = cell_point[i-1];
      end

      if (i == NEIGHBOUR_COUNT - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_dist  = '0;
         assign right_idx   = '0;
         assign right_point = '0;
      end else begin : g_link
         assign right_valid = cell_valid[i+1];
         assign right_dist  = cell_dist[i+1];
         assign right_idx   = cell_idx[i+1];
         assign right_point = cell_point[i+1];
      end

      knn_cell #(
         .IndexWidth (AW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .cand_dist   (s2_dist_ff),
         .cand_idx    (s2_idx_ff),
         .cand_point  (s2_point_ff),
         .prev_hit    (prev_hit),
         .left_valid  (left_valid),
         .left_dist   (left_dist),
         .left_idx    (left_idx),
         .left_point  (left_point),
         .right_valid (right_valid),
         .right_dist  (right_dist),
         .right_idx   (right_idx),
         .right_point (right_point),
         .hit         (cell_hit[i]),
         .valid       (cell_valid[i]),
         .slot_dist   (cell_dist[i]),
         .idx         (cell_idx[i]),
         .point       (cell_point[i])
      );
   end

   // result from the head cell, empty slots read as zero
   logic [COORD_W-1:0] out_x, out_y;
   logic [INDEX_W-1:0] out_idx;
   logic [DIST_W-1:0]  out_dist;

   assign out_x    = cell_valid[0] ? cell_point[0].row : '0;
   assign out_y    = cell_valid[0] ? cell_point[0].col : '0;
   assign out_idx  = cell_valid[0] ? INDEX_W'(cell_idx[0]) : '0;
   assign out_dist = cell_valid[0] ? cell_dist[0] : '0;

   assign rsp_tdata = {1'b0, out_dist, out_idx, out_y, out_x};
   assign rsp_tuser = cell_valid[0];
   assign rsp_tlast = (emit_ff == KW'(NEIGHBOUR_COUNT - 1));

endmodule
